// File: hdl/soundex_code_stream_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Soundex code stream core
// Concurrent checks sampled on clk_i and disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef SOUNDEX_CODE_STREAM_CORE_MACROS_SVH
`define SOUNDEX_CODE_STREAM_CORE_MACROS_SVH

// Same-cycle implication
`define SDX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SDX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sdx_pkg.sv
// ---------------------------------------------------------------------------
// sdx_pkg
// Shared types, constants and the letter-to-digit table of the Soundex core.
// ---------------------------------------------------------------------------
package sdx_pkg;

  // Default code length: lead character plus up to three digits
  localparam int SDX_CODE_LEN    = 4;
  localparam int SDX_DIGIT_SLOTS = 3;
  localparam int SDX_CHAR_W      = 8;
  localparam int SDX_DIGIT_W     = 3;
  localparam int SDX_IN_TDATA_W  = 8;
  localparam int SDX_OUT_TDATA_W = 24;

  // Digit codes; zero means no code / padded
  localparam logic [SDX_DIGIT_W-1:0] DIG_NONE   = 3'd0;
  localparam logic [SDX_DIGIT_W-1:0] DIG_LABIAL = 3'd1;  // b f p v
  localparam logic [SDX_DIGIT_W-1:0] DIG_GUTTER = 3'd2;  // c g j k q s x z
  localparam logic [SDX_DIGIT_W-1:0] DIG_DENTAL = 3'd3;  // d t
  localparam logic [SDX_DIGIT_W-1:0] DIG_LONG   = 3'd4;  // l
  localparam logic [SDX_DIGIT_W-1:0] DIG_NASAL  = 3'd5;  // m n
  localparam logic [SDX_DIGIT_W-1:0] DIG_ROLL   = 3'd6;  // r

  typedef logic [SDX_DIGIT_W-1:0] sdx_digit_t;

  // One finished code
  typedef struct packed {
    sdx_digit_t            digit_three;
    sdx_digit_t            digit_two;
    sdx_digit_t            digit_one;
    logic [SDX_CHAR_W-1:0] lead_char;
  } sdx_result_t;

  // Lower-case letter to digit; everything else has no code
  function automatic sdx_digit_t sdx_letter_code(input logic [SDX_CHAR_W-1:0] c);
    sdx_digit_t code;
    case (c) inside
      "b", "f", "p", "v":                     code = DIG_LABIAL;
      "c", "g", "j", "k", "q", "s", "x", "z": code = DIG_GUTTER;
      "d", "t":                               code = DIG_DENTAL;
      "l":                                    code = DIG_LONG;
      "m", "n":                               code = DIG_NASAL;
      "r":                                    code = DIG_ROLL;
      default:                                code = DIG_NONE;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/sdx_word.sv
// ---------------------------------------------------------------------------
// sdx_word
// Per-word state: lead character, run suppression and the kept digits.
// ---------------------------------------------------------------------------
module sdx_word #(
  parameter int CODE_LEN = sdx_pkg::SDX_CODE_LEN
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [sdx_pkg::SDX_CHAR_W-1:0]   ch_i,
  input  logic                             last_i,
  output logic                             res_valid_o,
  output sdx_pkg::sdx_result_t             res_o
);
  import sdx_pkg::*;

  // Number of digits kept, capped at the three slots
  localparam int KeepInt = ((CODE_LEN - 1) < SDX_DIGIT_SLOTS) ? (CODE_LEN - 1)
                                                               : SDX_DIGIT_SLOTS;
  localparam logic [1:0] KeepLimit = 2'(KeepInt);

  logic                  in_word_q, in_word_d;
  logic [SDX_CHAR_W-1:0] lead_q, lead_d;
  sdx_digit_t            prev_q, prev_d;
  logic [1:0]            cnt_q, cnt_d;
  sdx_digit_t            digits_q [SDX_DIGIT_SLOTS];
  sdx_digit_t            digits_d [SDX_DIGIT_SLOTS];
  sdx_digit_t            code;

  // Next state for the accepted character
  always_comb begin
    code      = sdx_letter_code(ch_i);
    in_word_d = in_word_q;
    lead_d    = lead_q;
    prev_d    = prev_q;
    cnt_d     = cnt_q;
    digits_d  = digits_q;
    if (!in_word_q) begin
      in_word_d = 1'b1;
      lead_d    = ch_i;
      prev_d    = DIG_NONE;
      cnt_d     = 2'd0;
      for (int i = 0; i < SDX_DIGIT_SLOTS; i++) digits_d[i] = DIG_NONE;
    end else if (code != DIG_NONE) begin
      if (code != prev_q && cnt_q < KeepLimit) begin
        digits_d[cnt_q] = code;
        cnt_d           = cnt_q + 2'd1;
      end
      prev_d = code;
    end
  end

  // Result goes out on the last character
  assign res_valid_o       = accept_i && last_i;
  assign res_o.lead_char   = lead_d;
  assign res_o.digit_one   = digits_d[0];
  assign res_o.digit_two   = digits_d[1];
  assign res_o.digit_three = digits_d[2];

  // State registers; the last character clears the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_word_q <= 1'b0;
      lead_q    <= '0;
      prev_q    <= DIG_NONE;
      cnt_q     <= 2'd0;
      for (int i = 0; i < SDX_DIGIT_SLOTS; i++) digits_q[i] <= DIG_NONE;
    end else if (accept_i) begin
      if (last_i) begin
        in_word_q <= 1'b0;
        lead_q    <= '0;
        prev_q    <= DIG_NONE;
        cnt_q     <= 2'd0;
        for (int i = 0; i < SDX_DIGIT_SLOTS; i++) digits_q[i] <= DIG_NONE;
      end else begin
        in_word_q <= in_word_d;
        lead_q    <= lead_d;
        prev_q    <= prev_d;
        cnt_q     <= cnt_d;
        digits_q  <= digits_d;
      end
    end
  end

endmodule

// File: hdl/sdx_out_buf.sv
// ---------------------------------------------------------------------------
// sdx_out_buf
// Output register with a skid entry, so input keeps flowing under a stall.
// ---------------------------------------------------------------------------
module sdx_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sdx_pkg::sdx_result_t push_data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 pop_ready_i,
  output sdx_pkg::sdx_result_t data_o
);
  import sdx_pkg::*;

  logic        out_valid_q, skid_valid_q;
  sdx_result_t out_q, skid_q;
  logic        pop;

  assign pop     = out_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  // Control: output slot refills from skid first, then from the push
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// File: hdl/soundex_code_stream_core.sv
// ---------------------------------------------------------------------------
// soundex_code_stream_core
// Streaming Soundex-style coder: characters in, one four-field code per word.
// ---------------------------------------------------------------------------
// Usage:
//   Slave side carries one character per transaction in s_axis_tdata[7:0];
//   s_axis_tlast marks the final character of a word. The first character is
//   the lead, later lower-case letters become digits 1..6 with runs merged.
//   On the last character one code transaction leaves on the master side.
//   Throughput: one character per cycle while s_axis_tready is high, set
//   by the single lookup/compare stage between the word state registers and
//   the output register. The code appears on m_axis_tvalid in the cycle after
//   the transaction that carries tlast when the output register is empty or
//   is read in that cycle; otherwise it waits in the skid entry until then.
//   Stall: an output register plus one skid entry hold results; with both
//   full, s_axis_tready drops until the receiver takes a code.
//   Reset (rst_ni low, asynchronous) drops any word in progress and any
//   pending code; the next character starts a new word.
// ---------------------------------------------------------------------------
module soundex_code_stream_core #(
  parameter int CODE_LEN = sdx_pkg::SDX_CODE_LEN
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sdx_pkg::SDX_IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] ch
  input  logic                                s_axis_tlast,   // last
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] lead_char, [10:8] digit_one, [13:11] digit_two,
  // [16:14] digit_three, [23:17] zero
  output logic [sdx_pkg::SDX_OUT_TDATA_W-1:0] m_axis_tdata
);
  import sdx_pkg::*;

  logic        accept;
  logic        res_valid;
  sdx_result_t res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Word state and digit lookup
  sdx_word #(
    .CODE_LEN (CODE_LEN)
  ) u_word (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (s_axis_tdata[SDX_CHAR_W-1:0]),
    .last_i      (s_axis_tlast),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register with skid entry
  sdx_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_res)
  );

  assign m_axis_tdata = SDX_OUT_TDATA_W'(out_res);

endmodule

// File: hdl/sdx_checker.sv
// ---------------------------------------------------------------------------
// sdx_checker
// Port-level checks of the Soundex core, bound to the top level.
// ---------------------------------------------------------------------------
`include "soundex_code_stream_core_macros.svh"

module sdx_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic                                s_axis_tlast,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [sdx_pkg::SDX_OUT_TDATA_W-1:0] m_axis_tdata
);
  import sdx_pkg::*;

  // Digits fill from the first slot up, pad bits stay clear
  `SDX_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:17] == 7'd0, "pad bits set")
  `SDX_ASSERT_SAME(a_digit_order, m_axis_tvalid && m_axis_tdata[10:8] == DIG_NONE,
    m_axis_tdata[13:11] == DIG_NONE && m_axis_tdata[16:14] == DIG_NONE, "digit after gap")
  // A last character into an empty output gives a code next cycle
  `SDX_ASSERT_NEXT(a_code_latency, s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid,
    m_axis_tvalid, "code missing after last character")
  // Stalled code holds
  `SDX_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled code changed")

endmodule

bind soundex_code_stream_core sdx_checker u_sdx_checker (.*);

// File: verif/soundex_code_checker.sv
// ---------------------------------------------------------------------------
// soundex_code_checker
// Watches both stream channels of the Soundex core. It predicts each finished
// code from the accepted characters and compares the codes leaving the block.
// ---------------------------------------------------------------------------
module soundex_code_checker #(
  parameter int CODE_LEN = sdx_pkg::SDX_CODE_LEN
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  input  logic                                s_tready_i,
  input  logic [sdx_pkg::SDX_IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                                s_tlast_i,
  input  logic                                m_tvalid_i,
  input  logic                                m_tready_i,
  input  logic [sdx_pkg::SDX_OUT_TDATA_W-1:0] m_tdata_i,
  output int unsigned                         mismatches_o,
  output int unsigned                         pending_o
);
  import sdx_pkg::*;

  // Digits kept per word: CODE_LEN-1, never more than the three slots
  localparam int KEEP_MAX = (CODE_LEN - 1 < SDX_DIGIT_SLOTS) ? CODE_LEN - 1 : SDX_DIGIT_SLOTS;

  // Word state of the predictor
  logic                  word_open;
  logic [SDX_CHAR_W-1:0] lead_q;
  sdx_digit_t            last_code;
  int unsigned           kept_cnt;
  sdx_digit_t            kept_digits [SDX_DIGIT_SLOTS];

  // Codes predicted but not yet seen on the master side
  sdx_result_t           code_q [$];
  int unsigned           mismatches = 0;

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
  end

  // Letter digits read from a table indexed by the letter's offset from 'a'
  function automatic sdx_digit_t char_code(input logic [SDX_CHAR_W-1:0] c);
    string map = "01230120022455012623010202";
    if (c >= "a" && c <= "z") begin
      return sdx_digit_t'(map[c - "a"] - "0");
    end
    return DIG_NONE;
  endfunction

  task automatic clear_word();
    word_open = 1'b0;
    lead_q    = '0;
    last_code = DIG_NONE;
    kept_cnt  = 0;
    foreach (kept_digits[i]) kept_digits[i] = DIG_NONE;
  endtask

  // One accepted character; a code is queued when the word ends
  task automatic absorb_char(input logic [SDX_CHAR_W-1:0] ch, input logic last);
    sdx_digit_t  code;
    sdx_result_t word_code;
    if (!word_open) begin
      clear_word();
      word_open = 1'b1;
      lead_q    = ch;
    end else begin
      code = char_code(ch);
      // uncoded bytes leave the run state alone
      if (code != DIG_NONE) begin
        if (code != last_code && kept_cnt < KEEP_MAX) begin
          kept_digits[kept_cnt] = code;
          kept_cnt++;
        end
        last_code = code;
      end
    end
    if (last) begin
      word_code.lead_char   = lead_q;
      word_code.digit_one   = kept_digits[0];
      word_code.digit_two   = kept_digits[1];
      word_code.digit_three = kept_digits[2];
      code_q = {code_q, word_code};
      clear_word();
    end
  endtask

  // Compare one code leaving the block with the oldest prediction
  task automatic check_code(input sdx_result_t got);
    sdx_result_t want;
    if (code_q.size() == 0) begin
      if (mismatches < 10) begin
        $display("unexpected code: lead %02h digits %0d %0d %0d", got.lead_char,
                 got.digit_one, got.digit_two, got.digit_three);
      end
      mismatches++;
    end else begin
      want = code_q.pop_front();
      if (got.lead_char !== want.lead_char || got.digit_one !== want.digit_one ||
          got.digit_two !== want.digit_two || got.digit_three !== want.digit_three) begin
        if (mismatches < 10) begin
          $display("code mismatch: expected lead %02h digits %0d %0d %0d, got lead %02h digits %0d %0d %0d",
                   want.lead_char, want.digit_one, want.digit_two, want.digit_three,
                   got.lead_char, got.digit_one, got.digit_two, got.digit_three);
        end
        mismatches++;
      end
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_word();
      code_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        check_code(m_tdata_i[$bits(sdx_result_t)-1:0]);
      end
      if (s_tvalid_i && s_tready_i) begin
        absorb_char(s_tdata_i[SDX_CHAR_W-1:0], s_tlast_i);
      end
    end
    pending_o    <= code_q.size();
    mismatches_o <= mismatches;
  end

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench top for soundex_code_stream_core: drives words one character per
// transaction, stalls the code receiver at random and gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import sdx_pkg::*;

  localparam int RAND_CHARS = 400;
  localparam int LONG_HOLD  = 300;
  localparam int IDLE_LIMIT = 2000;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [SDX_IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [SDX_OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned mismatches;
  int unsigned pending;

  // Sender and receiver pacing
  bit          src_gappy  = 1'b1;
  bit          rx_gappy   = 1'b1;
  int unsigned hold_req   = 0;
  logic        rx_holding = 1'b0;
  int unsigned rand_sent  = 0;
  int unsigned idle_cycles = 0;

  soundex_code_stream_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] ch
    .s_axis_tlast  (s_axis_tlast),   // last
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [7:0] lead, [10:8] [13:11] [16:14] digits
  );

  soundex_code_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len(input bit gappy);
    int unsigned r;
    if (!gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Character mix biased toward coded letters, with upper case and raw bytes
  function automatic logic [7:0] rand_char();
    string       coded  = "bfpvcgjkqsxzdtlmnr";
    string       silent = "aeiouhwy";
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(97, 122));
    if (r < 70) return coded[$urandom_range(0, coded.len() - 1)];
    if (r < 80) return 8'($urandom_range(65, 90));
    if (r < 88) return silent[$urandom_range(0, silent.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // One character transaction; valid stays up when no gap follows
  task automatic push_char(input logic [7:0] ch, input logic last);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    gap = idle_len(src_gappy);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_word(input string w);
    for (int i = 0; i < w.len(); i++) begin
      push_char(w[i], i == w.len() - 1);
    end
  endtask

  task automatic push_rand_word(input int unsigned len);
    logic [7:0] ch;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0 && $urandom_range(0, 5) == 0) begin
        ch = 8'($urandom_range(0, 255));
      end else begin
        ch = rand_char();
      end
      push_char(ch, i == len - 1);
    end
  endtask

  // Stimulus
  initial begin
    int unsigned r;
    int unsigned len;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One-character words, including the byte extremes
    push_char("a", 1'b1);
    push_char(8'h00, 1'b1);
    push_char(8'hff, 1'b1);
    // lead letter does not suppress its own digit
    push_word("bbf");
    // digit-like lead is only a character
    push_word("2b");
    // vowels do not separate runs
    push_word("tymczak");
    // digits past the limit still feed run suppression
    push_word("rbdlmnr");
    // high bytes and upper case are skipped
    push_char("d", 1'b0);
    push_char(8'h80, 1'b0);
    push_char("B", 1'b0);
    push_char("t", 1'b1);

    // Receiver holds off while short words arrive back to back
    s_axis_tvalid <= 1'b0;
    src_gappy = 1'b0;
    hold_req <= hold_req + 1;
    @(posedge clk_i);
    while (!rx_holding) @(posedge clk_i);
    repeat (20) push_rand_word($urandom_range(1, 2));
    src_gappy = 1'b1;

    // Random words, mostly of common length
    while (rand_sent < RAND_CHARS) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 85) len = $urandom_range(2, 8);
      else len = $urandom_range(9, 14);
      if ($urandom_range(0, 5) == 0) src_gappy = !src_gappy;
      push_rand_word(len);
      rand_sent += len;
    end
    s_axis_tvalid <= 1'b0;

    // Drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold on request
  initial begin
    int unsigned hold_seen;
    int unsigned gap;
    hold_seen = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        rx_holding    <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_holding    <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        gap = idle_len(rx_gappy);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        if ($urandom_range(0, 15) == 0) rx_gappy = !rx_gappy;
      end
    end
  end

  // Watchdog: cycles in which neither channel moves a transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
